// File: sv/psu_pkg.sv
package psu_pkg;

  // Column index width: covers every column of a line of up to 65536 bytes
  localparam int POS_W = 16;
  localparam int CFG_W = 14;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef enum logic {
    CFG_LINE_BYTES = 1'b0,
    CFG_BPP        = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       end_of_line;
    logic       bad_filter;
  } out_t;

  // Work item from the line tracker to the reconstruction pipe
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    filt_e            filt;
    logic             first_row;
    logic             last;
    logic             err;
  } op_t;

endpackage

// File: sv/psu_fifo.sv
module psu_fifo #(
  parameter type T = logic [7:0]
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     din_i,
  output logic full_o,
  input  logic pop_i,
  output T     dout_o,
  output logic empty_o
);

  T           slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// File: sv/psu_front.sv
module psu_front #(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  psu_pkg::in_t               item_i,
  input  logic [psu_pkg::CFG_W-1:0]  line_bytes_i,
  output logic                       op_push_o,
  output psu_pkg::op_t               op_o
);
  import psu_pkg::*;

  localparam int AW  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int LW0 = $clog2(MAX_LINE_BYTES + 1);
  localparam int LW  = (LW0 > CFG_W) ? LW0 : CFG_W;

  logic          halted_q, halted_d;
  logic          await_q, await_d;
  logic          first_q, first_d;
  logic [AW-1:0] pos_q, pos_d;
  filt_e         filt_q, filt_d;

  logic          halted_v, await_v, first_v;
  logic [AW-1:0] pos_v;
  logic [LW-1:0] len_eff, len_cfg, pos_next;
  logic          last;

  always_comb begin
    len_cfg = LW'(line_bytes_i);
    if (len_cfg == '0) begin
      len_eff = LW'(1);
    end else if (len_cfg > LW'(MAX_LINE_BYTES)) begin
      len_eff = LW'(MAX_LINE_BYTES);
    end else begin
      len_eff = len_cfg;
    end
  end

  always_comb begin
    halted_v = halted_q;
    await_v  = await_q;
    first_v  = first_q;
    pos_v    = pos_q;
    // image start restarts the tracker even mid-line or when halted
    if (item_i.image_start) begin
      halted_v = 1'b0;
      await_v  = 1'b1;
      first_v  = 1'b1;
      pos_v    = '0;
    end
    pos_next = LW'(pos_v) + LW'(1);
    last     = (pos_next >= len_eff);

    halted_d  = halted_q;
    await_d   = await_q;
    first_d   = first_q;
    pos_d     = pos_q;
    filt_d    = filt_q;
    op_push_o = 1'b0;
    op_o      = '0;
    op_o.data      = item_i.data_byte;
    op_o.pos       = POS_W'(pos_v);
    op_o.filt      = filt_q;
    op_o.first_row = first_v;
    op_o.last      = last;

    if (acc_i) begin
      halted_d = halted_v;
      await_d  = await_v;
      first_d  = first_v;
      pos_d    = pos_v;
      if (!halted_v) begin
        if (await_v) begin
          if (item_i.data_byte > 8'(FILT_PAETH)) begin
            halted_d  = 1'b1;
            op_push_o = 1'b1;
            op_o.err  = 1'b1;
          end else begin
            filt_d  = filt_e'(item_i.data_byte[2:0]);
            await_d = 1'b0;
            pos_d   = '0;
          end
        end else begin
          op_push_o = 1'b1;
          if (last) begin
            pos_d   = '0;
            await_d = 1'b1;
            first_d = 1'b0;
          end else begin
            pos_d = AW'(pos_next);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      await_q  <= 1'b1;
      first_q  <= 1'b1;
      pos_q    <= '0;
      filt_q   <= FILT_NONE;
    end else begin
      halted_q <= halted_d;
      await_q  <= await_d;
      first_q  <= first_d;
      pos_q    <= pos_d;
      filt_q   <= filt_d;
    end
  end

endmodule

// File: sv/psu_back.sv
module psu_back #(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_vld_i,
  input  psu_pkg::op_t op_i,
  output logic         op_pop_o,
  input  logic [3:0]   bpp_i,
  output logic         res_push_o,
  output psu_pkg::out_t res_o,
  input  logic         res_full_i
);
  import psu_pkg::*;

  localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

  logic [7:0]  line_mem [MAX_LINE_BYTES];

  logic        s2_vld_q, s2_vld_d;
  op_t         s2_op_q;
  logic [7:0]  rd_q;
  logic        byp_q;
  logic [7:0]  byp_data_q;
  logic [63:0] left_q, left_d;
  logic [63:0] upleft_q, upleft_d;

  logic          s2_fire, s1_take, wr_en;
  logic [AW-1:0] raddr, waddr;
  logic [3:0]    bpp_eff;
  logic [2:0]    tap;
  logic [7:0]    a, b, c, above, pred, recon;
  logic [8:0]    sum_ab;
  logic [9:0]    d_ac, d_bc, d_p, pa, pb, pc;

  assign s2_fire  = s2_vld_q & ~res_full_i;
  assign s1_take  = op_vld_i & (~s2_vld_q | s2_fire);
  assign op_pop_o = s1_take;
  assign raddr    = op_i.pos[AW-1:0];
  assign waddr    = s2_op_q.pos[AW-1:0];
  assign wr_en    = s2_fire & ~s2_op_q.err;
  assign s2_vld_d = s1_take | (s2_vld_q & ~s2_fire);

  always_comb begin
    if (bpp_i == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_i > 4'd8) begin
      bpp_eff = 4'd8;
    end else begin
      bpp_eff = bpp_i;
    end
    tap = 3'(bpp_eff - 4'd1);
  end

  always_comb begin
    above = byp_q ? byp_data_q : rd_q;
    b     = s2_op_q.first_row ? 8'd0 : above;
    // left neighbors exist only once a full pixel of this line is behind
    if (s2_op_q.pos >= POS_W'(bpp_eff)) begin
      a = left_q[{tap, 3'b000} +: 8];
      c = upleft_q[{tap, 3'b000} +: 8];
    end else begin
      a = 8'd0;
      c = 8'd0;
    end

    sum_ab = {1'b0, a} + {1'b0, b};
    d_ac   = {2'b00, a} - {2'b00, c};
    d_bc   = {2'b00, b} - {2'b00, c};
    d_p    = d_ac + d_bc;
    pa     = d_bc[9] ? -d_bc : d_bc;
    pb     = d_ac[9] ? -d_ac : d_ac;
    pc     = d_p[9]  ? -d_p  : d_p;

    case (s2_op_q.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    recon = s2_op_q.data + pred;

    left_d   = left_q;
    upleft_d = upleft_q;
    if (wr_en) begin
      left_d   = {left_q[55:0], recon};
      upleft_d = {upleft_q[55:0], b};
    end

    res_push_o = s2_fire;
    if (s2_op_q.err) begin
      res_o = '{pixel_byte: 8'd0, end_of_line: 1'b0, bad_filter: 1'b1};
    end else begin
      res_o = '{pixel_byte: recon, end_of_line: s2_op_q.last, bad_filter: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      left_q   <= '0;
      upleft_q <= '0;
    end else begin
      s2_vld_q <= s2_vld_d;
      left_q   <= left_d;
      upleft_q <= upleft_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[waddr] <= recon;
    end
    if (s1_take) begin
      s2_op_q    <= op_i;
      rd_q       <= line_mem[raddr];
      // forward the byte being written to the same column this cycle
      byp_q      <= wr_en && (waddr == raddr);
      byp_data_q <= recon;
    end
  end

endmodule

// File: sv/png_scanline_unfilter_top.sv
// Channel   Direction  Handshake              Payload
// input     in         push / full            in_item_i  (data_byte, image_start)
// result    out        empty / pop            out_item_o (pixel_byte, end_of_line, bad_filter)
// config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One byte per cycle sustained while the result queue drains; a taken byte passes the op queue,
// the line-store read stage and reconstruct, then the result queue, before its result reaches the ports.
// Throughput is set by the single line-store read and write per byte, one each cycle.
// Reset clears all control state; the line store holds no reset, and its read data
// is ignored on the first row of an image.
// Two-entry queues between tracker and pipe and at the result side absorb stalls.
module png_scanline_unfilter_top #(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  psu_pkg::in_t               in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output psu_pkg::out_t              out_item_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [psu_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import psu_pkg::*;

  logic [CFG_W-1:0] line_bytes_q;
  logic [3:0]       bpp_q;

  logic  acc;
  logic  op_push, op_full, op_empty, op_pop;
  op_t   op_in, op_out;
  logic  res_push, res_full;
  out_t  res;

  assign acc = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= CFG_W'(1);
      bpp_q        <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_BYTES: line_bytes_q <= cfg_wdata_i;
        CFG_BPP:        bpp_q        <= cfg_wdata_i[3:0];
        default:        ;
      endcase
    end
  end

  psu_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .item_i      (in_item_i),
    .line_bytes_i(line_bytes_q),
    .op_push_o   (op_push),
    .op_o        (op_in)
  );

  psu_fifo #(
    .T(op_t)
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .din_i  (op_in),
    .full_o (op_full),
    .pop_i  (op_pop),
    .dout_o (op_out),
    .empty_o(op_empty)
  );

  assign full = op_full;

  psu_back #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_vld_i  (~op_empty),
    .op_i      (op_out),
    .op_pop_o  (op_pop),
    .bpp_i     (bpp_q),
    .res_push_o(res_push),
    .res_o     (res),
    .res_full_i(res_full)
  );

  psu_fifo #(
    .T(out_t)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .din_i  (res),
    .full_o (res_full),
    .pop_i  (pop),
    .dout_o (out_item_o),
    .empty_o(empty)
  );

endmodule
